/* design/fbpa_pkg.sv */
// Shared constants and codes for the fixed block pool allocator.
// No dependencies; imported by fbpa_stack_ram and fixed_block_pool_allocator_top.
`default_nettype none

package fbpa_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W  = 32;
  localparam int SIZE_W  = 16;
  localparam int COUNT_W = 9;
  localparam int REG_IDX_W = 2;

  // Default stack depth.
  localparam int DEFAULT_MAX_BLOCKS = 256;

  // Reset values of the configuration registers.
  localparam logic [ADDR_W-1:0]  RESET_BASE_ADDRESS = '0;
  localparam logic [SIZE_W-1:0]  RESET_BLOCK_SIZE   = 16'd64;
  localparam logic [COUNT_W-1:0] RESET_BLOCK_COUNT  = 9'd256;

  // Configuration register indexes.
  typedef enum logic [REG_IDX_W-1:0] {
    REG_BASE_ADDRESS = 2'd0,
    REG_BLOCK_SIZE   = 2'd1,
    REG_BLOCK_COUNT  = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_index_t;

  // Request operations.
  typedef enum logic {
    FUNC_ALLOC = 1'b0,
    FUNC_FREE  = 1'b1
  } func_t;

endpackage

`default_nettype wire

/* design/fbpa_stack_ram.sv */
// Single-port-write, single-port-read memory holding the free address stack.
// Depends on fbpa_pkg for the data width.
`default_nettype none

module fbpa_stack_ram #(
  parameter int  DEPTH = fbpa_pkg::DEFAULT_MAX_BLOCKS,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [AW-1:0]               waddr,
  input  wire logic [fbpa_pkg::ADDR_W-1:0] wdata,
  input  wire logic [AW-1:0]               raddr,
  output logic      [fbpa_pkg::ADDR_W-1:0] rdata
);
  import fbpa_pkg::*;

  logic [ADDR_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read: data appears in the cycle after the address.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* design/fixed_block_pool_allocator_top.sv */
// Top level of the fixed block pool allocator: control, pool range check and byte count.
// Depends on fbpa_pkg and fbpa_stack_ram.
`default_nettype none

// Channel     Direction  Ports                                      Handshake
// config      in         cfg_write, cfg_index, cfg_data             write at edge with cfg_write
// request     in         start, func, free_address                  accepted at start & !busy
// result      out        done, block_address, from_pool,            valid for the one cycle
//                        stack_overflow, spill_bytes                where done is high
//
// A new request may be accepted at every edge while busy is low. The result shows in the
// cycle after the request is accepted, since a pop reads the stack memory, which has a
// registered read. After reset, and after every write to a known register, busy stays
// high while the stack memory is refilled one entry per cycle; the byte count is cleared
// and the stack is marked full. The receiver cannot stall results, so done is a plain
// one-cycle strobe.

module fixed_block_pool_allocator_top #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Configuration port.
  input  wire logic                                  cfg_write,
  input  wire logic [fbpa_pkg::REG_IDX_W-1:0]        cfg_index,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]           cfg_data,
  // Request.
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic                                  func,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]           free_address,
  // Result.
  output logic                                       done,
  output logic      [fbpa_pkg::ADDR_W-1:0]           block_address,
  output logic                                       from_pool,
  output logic                                       stack_overflow,
  output logic signed [fbpa_pkg::ADDR_W-1:0]         spill_bytes
);
  import fbpa_pkg::*;

  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = $clog2(MAX_BLOCKS + 1);
  localparam int PW   = SIZE_W + CW;
  localparam int HI_W = (PW > ADDR_W ? PW : ADDR_W) + 1;

  // Configuration registers.
  logic [ADDR_W-1:0]  base_address;
  logic [SIZE_W-1:0]  block_size;
  logic [COUNT_W-1:0] block_count;

  // Refill sequencer.
  logic              refill_active;
  logic [IW-1:0]     refill_idx;
  logic [ADDR_W-1:0] refill_acc;
  logic [ADDR_W-1:0] refill_value;

  // Stack state.
  logic [CW-1:0]     free_count;
  logic [ADDR_W-1:0] overflow_bytes;

  // Pool range, recomputed from the configuration in two registered steps.
  logic [PW-1:0]     range_bytes;
  logic [HI_W-1:0]   pool_end;

  logic [CW-1:0]     eff_count;
  logic              accept;
  logic              is_alloc;
  logic              can_pop;
  logic              in_pool;
  logic              stack_full;
  logic              do_pop;
  logic              do_push;
  logic              known_reg;
  logic              pop_served;

  // RAM connections.
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [ADDR_W-1:0] ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [ADDR_W-1:0] ram_rdata;

  // The effective block count saturates at the stack depth.
  always_comb begin
    if (32'(block_count) > 32'(MAX_BLOCKS)) begin
      eff_count = CW'(MAX_BLOCKS);
    end else begin
      eff_count = CW'(32'(block_count));
    end
  end

  always_ff @(posedge clk) begin
    range_bytes <= PW'(block_size) * PW'(eff_count);
    pool_end    <= HI_W'(base_address) + HI_W'(range_bytes);
  end

  assign busy       = refill_active;
  assign accept     = start && !busy;
  assign is_alloc   = (func == FUNC_ALLOC);
  assign can_pop    = (free_count != '0);
  assign in_pool    = (HI_W'(free_address) >= HI_W'(base_address)) &&
                      (HI_W'(free_address) < pool_end);
  assign stack_full = (free_count >= eff_count);
  assign do_pop     = accept && is_alloc && can_pop;
  assign do_push    = accept && !is_alloc && in_pool && !stack_full;

  always_comb begin
    unique case (reg_index_t'(cfg_index))
      REG_BASE_ADDRESS, REG_BLOCK_SIZE, REG_BLOCK_COUNT: known_reg = 1'b1;
      default:                                           known_reg = 1'b0;
    endcase
  end

  // The first refill entry is the base itself; later ones step by the block size.
  assign refill_value = (refill_idx == '0) ? base_address : refill_acc;

  // One write port shared by the refill sweep and pushes, which never overlap.
  always_comb begin
    if (refill_active) begin
      ram_we    = 1'b1;
      ram_waddr = refill_idx;
      ram_wdata = refill_value;
    end else begin
      ram_we    = do_push;
      ram_waddr = free_count[IW-1:0];
      ram_wdata = free_address;
    end
  end

  // A pop reads the current top entry; a push in the next cycle cannot disturb it,
  // and a pop after a push reads at a later edge than the write.
  assign ram_raddr = IW'(free_count - CW'(1));

  fbpa_stack_ram #(
    .DEPTH (MAX_BLOCKS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration registers and refill control.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_address  <= RESET_BASE_ADDRESS;
      block_size    <= RESET_BLOCK_SIZE;
      block_count   <= RESET_BLOCK_COUNT;
      refill_active <= 1'b1;
      refill_idx    <= '0;
    end else if (cfg_write && known_reg) begin
      unique case (reg_index_t'(cfg_index))
        REG_BASE_ADDRESS: base_address <= cfg_data;
        REG_BLOCK_SIZE:   block_size   <= cfg_data[SIZE_W-1:0];
        REG_BLOCK_COUNT:  block_count  <= cfg_data[COUNT_W-1:0];
        default:          ;
      endcase
      refill_active <= 1'b1;
      refill_idx    <= '0;
    end else if (refill_active) begin
      if (32'(refill_idx) == MAX_BLOCKS - 1) begin
        refill_active <= 1'b0;
      end
      refill_idx <= refill_idx + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    refill_acc <= refill_value + ADDR_W'(block_size);
  end

  // Stack pointer and overflow byte count.
  always_ff @(posedge clk) begin
    if (rst || (cfg_write && known_reg)) begin
      free_count     <= '0;
      overflow_bytes <= '0;
    end else if (refill_active) begin
      // Holds the full count once the sweep ends.
      free_count <= eff_count;
    end else if (accept) begin
      if (is_alloc) begin
        if (can_pop) begin
          free_count <= free_count - CW'(1);
        end else begin
          overflow_bytes <= overflow_bytes + ADDR_W'(block_size);
        end
      end else if (in_pool) begin
        if (!stack_full) begin
          free_count <= free_count + CW'(1);
        end
      end else begin
        overflow_bytes <= overflow_bytes - ADDR_W'(block_size);
      end
    end
  end

  // Result registers; the popped address comes straight from the memory's registered read.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pop_served     <= do_pop;
      from_pool      <= is_alloc ? can_pop : in_pool;
      stack_overflow <= !is_alloc && in_pool && stack_full;
    end
  end

  assign block_address = pop_served ? ram_rdata : '0;
  assign spill_bytes   = overflow_bytes;

endmodule

`default_nettype wire

/* tb/fbpa_grant_checker.sv */
`timescale 1ns / 100ps
// Checker for the fixed block pool allocator: tracks the pool state, predicts each result
// from the accepted requests and compares it with the block's result port.
// Depends on fbpa_pkg.

module fbpa_grant_checker #(
  parameter int MAX_BLOCKS = fbpa_pkg::DEFAULT_MAX_BLOCKS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [fbpa_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
  input  wire logic                           start,
  input  wire logic                           busy,
  input  wire logic                           func,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    free_address,
  input  wire logic                           done,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    block_address,
  input  wire logic                           from_pool,
  input  wire logic                           stack_overflow,
  input  wire logic [fbpa_pkg::ADDR_W-1:0]    spill_bytes,
  output int                                  pending,
  output int                                  mismatches
);
  import fbpa_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              pool;
    logic              ovf;
    logic [ADDR_W-1:0] bytes;
  } grant_t;

  logic [ADDR_W-1:0]  stack_mem [MAX_BLOCKS];
  int unsigned        stack_fill;
  logic [ADDR_W-1:0]  byte_balance;
  logic [ADDR_W-1:0]  pool_base;
  logic [SIZE_W-1:0]  pool_size;
  logic [COUNT_W-1:0] pool_count;

  grant_t pending_grants [$];
  int     pending_q_size = 0;
  int     mismatch_count = 0;

  assign pending    = pending_q_size;
  assign mismatches = mismatch_count;

  function automatic int unsigned live_blocks();
    return (pool_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(pool_count);
  endfunction

  // Refill the stack with every block address, mark it full and clear the byte balance.
  function automatic void restock();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      stack_mem[i] = pool_base + ADDR_W'(i * pool_size);
    end
    stack_fill   = live_blocks();
    byte_balance = '0;
  endfunction

  function automatic grant_t predict_grant(func_t op, logic [ADDR_W-1:0] addr);
    grant_t             g;
    logic [2*ADDR_W-1:0] limit;
    g = '0;
    if (op == FUNC_ALLOC) begin
      if (stack_fill > 0) begin
        stack_fill--;
        g.addr = stack_mem[stack_fill];
        g.pool = 1'b1;
      end else begin
        byte_balance = byte_balance + ADDR_W'(pool_size);
      end
    end else begin
      // The upper bound does not wrap, so wrapped block addresses count as outside.
      limit = (2*ADDR_W)'(pool_base) + (2*ADDR_W)'(pool_size) * (2*ADDR_W)'(live_blocks());
      if (addr >= pool_base && (2*ADDR_W)'(addr) < limit) begin
        g.pool = 1'b1;
        if (stack_fill >= live_blocks()) begin
          g.ovf = 1'b1;
        end else begin
          stack_mem[stack_fill] = addr;
          stack_fill++;
        end
      end else begin
        byte_balance = byte_balance - ADDR_W'(pool_size);
      end
    end
    g.bytes = byte_balance;
    return g;
  endfunction

  task automatic flag_mismatch(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
    $display("%0t checker: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    grant_t want;
    if (rst) begin
      pending_grants.delete();
      pool_base  = RESET_BASE_ADDRESS;
      pool_size  = RESET_BLOCK_SIZE;
      pool_count = RESET_BLOCK_COUNT;
      restock();
    end else begin
      if (done) begin
        if (pending_grants.size() == 0) begin
          flag_mismatch("result with no request pending", block_address, '0);
        end else begin
          want = pending_grants.pop_front();
          if (block_address !== want.addr) begin
            flag_mismatch("block_address", block_address, want.addr);
          end
          if (from_pool !== want.pool) begin
            flag_mismatch("from_pool", ADDR_W'(from_pool), ADDR_W'(want.pool));
          end
          if (stack_overflow !== want.ovf) begin
            flag_mismatch("stack_overflow", ADDR_W'(stack_overflow), ADDR_W'(want.ovf));
          end
          if (spill_bytes !== want.bytes) begin
            flag_mismatch("spill_bytes", spill_bytes, want.bytes);
          end
        end
      end
      if (cfg_write) begin
        case (reg_index_t'(cfg_index))
          REG_BASE_ADDRESS: pool_base  = cfg_data;
          REG_BLOCK_SIZE:   pool_size  = cfg_data[SIZE_W-1:0];
          REG_BLOCK_COUNT:  pool_count = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
        if (reg_index_t'(cfg_index) != REG_UNUSED) begin
          restock();
        end
      end
      if (start && !busy) begin
        pending_grants.push_back(predict_grant(func_t'(func), free_address));
      end
    end
    pending_q_size <= pending_grants.size();
  end

endmodule

/* tb/tb_fixed_block_pool_allocator_top.sv */
`timescale 1ns / 100ps
// Testbench top for the fixed block pool allocator: clock, reset, request and register
// stimulus, watchdog and verdict. Depends on fbpa_pkg, the block and fbpa_grant_checker.

module tb_fixed_block_pool_allocator_top;
  import fbpa_pkg::*;

  localparam int DEPTH = DEFAULT_MAX_BLOCKS;
  // A refill keeps busy high until the stack is full; refills and gaps stay far below this limit.
  localparam int IDLE_LIMIT = 4 * DEPTH + 1000;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 125;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_write = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index = REG_BASE_ADDRESS;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 func = FUNC_ALLOC;
  logic [ADDR_W-1:0]    free_address = '0;
  logic                 done;
  logic [ADDR_W-1:0]    block_address;
  logic                 from_pool;
  logic                 stack_overflow;
  logic signed [ADDR_W-1:0] spill_bytes;

  int pending;
  int mismatches;
  int idle_cycles = 0;

  // Stimulus-side view of the pool, used to aim requests at the pool range and its edges and to size bursts.
  logic [ADDR_W-1:0]  cur_base = RESET_BASE_ADDRESS;
  logic [SIZE_W-1:0]  cur_size = RESET_BLOCK_SIZE;
  logic [COUNT_W-1:0] cur_count = RESET_BLOCK_COUNT;
  int unsigned        cur_live = DEPTH;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  fixed_block_pool_allocator_top #(
    .MAX_BLOCKS(DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .func(func),
    .free_address(free_address),
    .done(done),
    .block_address(block_address),
    .from_pool(from_pool),
    .stack_overflow(stack_overflow),
    .spill_bytes(spill_bytes)
  );

  fbpa_grant_checker #(
    .MAX_BLOCKS(DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .start(start),
    .busy(busy),
    .func(func),
    .free_address(free_address),
    .done(done),
    .block_address(block_address),
    .from_pool(from_pool),
    .stack_overflow(stack_overflow),
    .spill_bytes(spill_bytes),
    .pending(pending),
    .mismatches(mismatches)
  );

  // The watchdog counts cycles in which no request, result or register write moves.
  // Refills after reset and after register writes are the longest legal stretches.
  always @(posedge clk) begin
    if (rst || cfg_write || done || (start && !busy)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_fixed_block_pool_allocator_top: done, errors");
        $finish;
      end
    end
  end

  // Most gaps are short, a few are long; tight bursts have none at all.
  function automatic int unsigned pick_gap(bit tight);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (tight || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A block address inside the pool, sometimes with an offset into the block.
  // Addresses that wrap past the top of the address space land outside the range.
  function automatic logic [ADDR_W-1:0] pool_addr();
    logic [ADDR_W-1:0] a;
    if (cur_live == 0) return cur_base;
    a = cur_base + ADDR_W'($urandom_range(0, cur_live - 1) * cur_size);
    if (cur_size > 1 && $urandom_range(0, 3) == 0) begin
      a = a + $urandom_range(0, cur_size - 1);
    end
    return a;
  endfunction

  // Present one request and hold it until the block takes it. When the next request
  // follows with no gap, start simply stays high and only the payload changes.
  task automatic send(func_t op, logic [ADDR_W-1:0] addr, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    func         <= op;
    free_address <= addr;
    do @(posedge clk); while (busy);
  endtask

  // Stop requesting and wait until every expected result has come back.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Register writes happen only while idle; a known register starts a refill,
  // which holds busy high until the stack is full again.
  task automatic set_reg(reg_index_t idx, logic [ADDR_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    do @(posedge clk); while (busy);
    case (idx)
      REG_BASE_ADDRESS: cur_base  = val;
      REG_BLOCK_SIZE:   cur_size  = val[SIZE_W-1:0];
      REG_BLOCK_COUNT:  cur_count = val[COUNT_W-1:0];
      default: ;
    endcase
    cur_live = (cur_count > DEPTH) ? DEPTH : cur_count;
  endtask

  initial begin : stimulus
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    bit          tight;
    logic [ADDR_W-1:0] base_v;
    logic [ADDR_W-1:0] size_v;
    logic [ADDR_W-1:0] count_v;
    logic [ADDR_W-1:0] edge_a;

    // Synchronous reset, then the block refills the stack itself.
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part, reset settings: a free onto the full stack, allocates,
    // frees at the top edge of the range and just past it, and an all-ones address.
    send(FUNC_FREE, 32'h0000_0000, 0);
    send(FUNC_ALLOC, 32'hFFFF_FFFF, 0);
    send(FUNC_ALLOC, 32'h0000_0000, 1);
    send(FUNC_FREE, 32'd16383, 0);
    send(FUNC_FREE, 32'd16384, 2);
    send(FUNC_FREE, 32'hFFFF_FFFF, 0);
    send(FUNC_ALLOC, 32'h0000_0000, 0);

    // A write to the unused index must leave the stack and the byte count alone.
    drain();
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send(FUNC_ALLOC, 32'h0000_0000, 0);

    // Pool near the top of the address space: two of four blocks wrap to low
    // addresses. Empty the stack, fall back once, then free a wrapped address,
    // one just below the base and the very last byte.
    drain();
    set_reg(REG_BASE_ADDRESS, 32'hFFFF_FF80);
    set_reg(REG_BLOCK_COUNT, 32'd4);
    repeat (5) send(FUNC_ALLOC, $urandom, 0);
    send(FUNC_FREE, 32'h0000_0000, 0);
    send(FUNC_FREE, 32'hFFFF_FF7F, 1);
    send(FUNC_FREE, 32'hFFFF_FFFF, 0);

    // No blocks in use: everything falls back or lies outside.
    drain();
    set_reg(REG_BLOCK_COUNT, 32'd0);
    send(FUNC_ALLOC, 32'h0000_0000, 0);
    send(FUNC_FREE, 32'hFFFF_FF80, 0);

    // Count above the stack depth saturates; a zero block size makes the range empty.
    drain();
    set_reg(REG_BLOCK_COUNT, 32'h0000_01FF);
    set_reg(REG_BLOCK_SIZE, 32'd0);
    send(FUNC_ALLOC, 32'h0000_0000, 0);
    send(FUNC_FREE, 32'hFFFF_FF80, 0);

    // Largest block size with a saturated count: last byte of the pool, then just past it.
    drain();
    set_reg(REG_BASE_ADDRESS, 32'h0000_0000);
    set_reg(REG_BLOCK_SIZE, 32'h0000_FFFF);
    set_reg(REG_BLOCK_COUNT, 32'd300);
    send(FUNC_FREE, 32'd16776959, 0);
    send(FUNC_ALLOC, 32'h0000_0000, 0);
    send(FUNC_FREE, 32'd16776960, 0);

    // Random part. Each phase picks new settings, mostly small pools so that the
    // stack swings between empty and full, then runs bursts of allocates, frees
    // aimed at the pool, and noise near the range edges.
    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      case ($urandom_range(0, 3))
        0: base_v = $urandom;
        1: base_v = '0;
        2: base_v = 32'hFFFF_FFFF - $urandom_range(0, 4096);
        default: base_v = $urandom & 32'hFFFF_F000;
      endcase
      case ($urandom_range(0, 9))
        0: size_v = 0;
        1: size_v = 32'h0000_FFFF;
        2, 3: size_v = $urandom_range(1, 65535);
        default: size_v = $urandom_range(1, 128);
      endcase
      case ($urandom_range(0, 9))
        0: count_v = 0;
        1: count_v = $urandom_range(256, 511);
        2: count_v = $urandom_range(17, 255);
        default: count_v = $urandom_range(1, 16);
      endcase
      // Bits above each register's width are junk that the block must ignore.
      set_reg(REG_BASE_ADDRESS, base_v);
      set_reg(REG_BLOCK_SIZE, ($urandom & 32'hFFFF_0000) | size_v);
      set_reg(REG_BLOCK_COUNT, ($urandom & 32'hFFFF_FE00) | count_v);

      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        kind  = $urandom_range(0, 9);
        tight = $urandom_range(0, 1);
        len   = $urandom_range(1, (cur_live + 3 > 40) ? 40 : cur_live + 3);
        // Now and then let the block run dry in the middle of a phase.
        if ($urandom_range(0, 19) == 0) drain();
        for (int k = 0; k < len; k++) begin
          if (kind < 4) begin
            send(FUNC_ALLOC, $urandom, pick_gap(tight));
          end else if (kind < 8) begin
            send(FUNC_FREE, pool_addr(), pick_gap(tight));
          end else begin
            case ($urandom_range(0, 3))
              0: edge_a = cur_base - 1;
              1: edge_a = cur_base + ADDR_W'(cur_size * cur_live);
              2: edge_a = cur_base + ADDR_W'(cur_size * cur_live) - 1;
              default: edge_a = $urandom;
            endcase
            send(func_t'($urandom_range(0, 1)), edge_a, pick_gap(tight));
          end
          sent++;
        end
      end
    end

    // Everything is accepted; wait for the last results and a quiet stretch, then give the verdict.
    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_fixed_block_pool_allocator_top: done, clean");
    end else begin
      $display("tb_fixed_block_pool_allocator_top: done, errors");
    end
    $finish;
  end

endmodule

/* fixed_block_pool_allocator_top.f */
design/fbpa_pkg.sv
design/fbpa_stack_ram.sv
design/fixed_block_pool_allocator_top.sv
tb/fbpa_grant_checker.sv
tb/tb_fixed_block_pool_allocator_top.sv
